// File: src/stbc_pkg.sv
// Shared types, constants and alphabet helpers of the six-bit text codec.
// Used by every module of the codec; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stbc_pkg;

    // Register indexes of the configuration port.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE            = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH      = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_DONE       = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Most results one input item can cause.
    localparam int unsigned JOB_SLOTS = 5;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // One queued job: the results caused by one input item. Only the last
    // result of a job can carry a status other than ok.
    typedef struct packed {
        logic [2:0]                 count;
        logic [1:0]                 last_status;
        logic [JOB_SLOTS-1:0][7:0]  data;
    } job_t;

    // Decoded alphabet character.
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sixbit_t;

    // Six-bit value to its alphabet character.
    function automatic logic [7:0] sixbit_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd10) begin
            c = CHAR_ZERO + {2'b00, v};
        end else if (v < 6'd36) begin
            c = CHAR_UPPER_A + {2'b00, v - 6'd10};
        end else if (v < 6'd62) begin
            c = CHAR_LOWER_A + {2'b00, v - 6'd36};
        end else if (v == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    // Alphabet character to its six-bit value; foreign characters are not valid.
    function automatic sixbit_t char_to_sixbit(input logic [7:0] c);
        sixbit_t r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - CHAR_ZERO);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - CHAR_UPPER_A + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - CHAR_LOWER_A + 8'd36);
        end else if (c == CHAR_PLUS) begin
            r.value = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/six_bit_text_codec.sv
// Top level of the six-bit text codec: front end, job queue and back end.
// Depends on stbc_pkg, stbc_front, stbc_queue and stbc_back.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_in_byte, s_is_last
//   m_        out        m_valid / m_ready    m_out_byte, m_run_last, m_status
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wr_data
//
// The front end takes one input request per cycle while the job queue has room
// and settles the whole item in that cycle. The back end hands out one result
// per cycle while m_ready is high, so throughput is set by the result count: an
// encoded group of three bytes gives four or five characters. With the back end
// idle, the first result of an item goes through the job queue and then the back
// end's job register before it is offered.
// Reset is synchronous and active low; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module six_bit_text_codec #(
    parameter int unsigned LINE_CHARS  = 80,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire  [stbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [stbc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [7:0]                          s_in_byte,
    input  wire                                 s_is_last,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_run_last,
    output logic [1:0]                          m_status
);

    stbc_pkg::job_t  front_job;
    stbc_pkg::job_t  queue_job;
    logic            job_push;
    logic            queue_full;
    logic            queue_empty;
    logic            queue_pop;

    // Classify items and build jobs.
    stbc_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_is_last   (s_is_last),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job         (front_job)
    );

    // Decouple the two ends.
    stbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (front_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_job),
        .empty     (queue_empty)
    );

    // Serialize results.
    stbc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (queue_empty),
        .q_data     (queue_job),
        .q_pop      (queue_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire

// File: src/stbc_front.sv
// Front end of the six-bit text codec: configuration registers, stream state,
// and turning each accepted input request into one job. Depends on stbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stbc_front #(
    parameter int unsigned LINE_CHARS = 80
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [stbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [stbc_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [7:0]                           s_in_byte,
    input  wire                                  s_is_last,
    input  wire                                  queue_full,
    output logic                                 job_push,
    output stbc_pkg::job_t                       job
);

    // Lines break between four-character groups only.
    localparam int unsigned LineLimit = (LINE_CHARS < 4) ? 4 : (LINE_CHARS - (LINE_CHARS % 4));
    localparam int unsigned LpW = $clog2(LineLimit + 1);
    localparam logic [LpW:0] LineLimitV = (LpW + 1)'(LineLimit);

    stbc_pkg::mode_t mode_reg;
    logic [15:0]     expected_reg;
    logic [15:0]     max_reg;

    logic [23:0]     bits_reg, bits_next;
    logic [2:0]      fill_reg, fill_next;
    logic [2:0]      valid_reg, valid_next;
    logic [LpW-1:0]  lp_reg, lp_next;
    logic [15:0]     produced_reg, produced_next;
    logic            line_start_reg, line_start_next;
    logic            stopped_reg, stopped_next;

    logic            accept;
    logic            len_bad;
    logic            flush_now;
    logic            emit;
    logic            newline;
    logic [2:0]      flush_count;
    logic [15:0]     remaining;
    logic [LpW:0]    lp_after;
    stbc_pkg::sixbit_t sym;
    logic [23:0]     sym_shifted;
    logic [23:0]     byte_shifted;

    assign s_ready = !queue_full;
    assign accept  = s_valid && !queue_full;
    assign job_push = accept && (job.count != 3'd0);

    assign len_bad = (expected_reg == 16'd0) || (expected_reg > max_reg);
    assign sym     = stbc_pkg::char_to_sixbit(s_in_byte);

    // Place a character value or a byte at the current group position.
    always_comb begin
        unique case (fill_reg[1:0])
            2'd0:    sym_shifted = {sym.value, 18'd0};
            2'd1:    sym_shifted = {6'd0, sym.value, 12'd0};
            2'd2:    sym_shifted = {12'd0, sym.value, 6'd0};
            default: sym_shifted = {18'd0, sym.value};
        endcase
        unique case (fill_reg[1:0])
            2'd0:    byte_shifted = {s_in_byte, 16'd0};
            2'd1:    byte_shifted = {8'd0, s_in_byte, 8'd0};
            default: byte_shifted = {16'd0, s_in_byte};
        endcase
    end

    // Next stream state and the job for the item on the input.
    always_comb begin
        bits_next       = bits_reg;
        fill_next       = fill_reg;
        valid_next      = valid_reg;
        lp_next         = lp_reg;
        produced_next   = produced_reg;
        line_start_next = line_start_reg;
        stopped_next    = stopped_reg;
        flush_now       = 1'b0;
        emit            = 1'b0;
        newline         = 1'b0;
        flush_count     = 3'd0;
        remaining       = 16'd0;
        lp_after        = {1'b0, lp_reg} + (LpW + 1)'(4);
        job.count       = 3'd0;
        job.last_status = stbc_pkg::STATUS_OK;
        job.data        = '0;

        if (mode_reg == stbc_pkg::MODE_ENCODE) begin
            // Gather bytes; a full or final group gives four characters.
            bits_next = bits_reg | byte_shifted;
            fill_next = fill_reg + 3'd1;
            emit      = (fill_next == 3'd3) || s_is_last;
            if (emit) begin
                newline     = s_is_last || (lp_after >= LineLimitV);
                job.data[0] = stbc_pkg::sixbit_to_char(bits_next[23:18]);
                job.data[1] = stbc_pkg::sixbit_to_char(bits_next[17:12]);
                job.data[2] = stbc_pkg::sixbit_to_char(bits_next[11:6]);
                job.data[3] = stbc_pkg::sixbit_to_char(bits_next[5:0]);
                job.data[4] = stbc_pkg::CHAR_NL;
                job.count   = newline ? 3'd5 : 3'd4;
                lp_next     = newline ? '0 : lp_after[LpW-1:0];
                bits_next   = '0;
                fill_next   = 3'd0;
            end
        end else if (len_bad) begin
            // Bad length setting: report it and leave the stream alone.
            job.count       = 3'd1;
            job.last_status = stbc_pkg::STATUS_BAD_LENGTH;
        end else begin
            if (!stopped_reg && (s_in_byte != stbc_pkg::CHAR_CR)) begin
                if (s_in_byte == stbc_pkg::CHAR_NL) begin
                    flush_now       = 1'b1;
                    line_start_next = 1'b1;
                end else if (line_start_reg && ((s_in_byte == stbc_pkg::CHAR_HASH) ||
                                                (s_in_byte == stbc_pkg::CHAR_DASH))) begin
                    stopped_next    = 1'b1;
                    job.count       = 3'd1;
                    job.last_status = stbc_pkg::STATUS_DONE;
                end else begin
                    line_start_next = 1'b0;
                    if (sym.valid) begin
                        bits_next  = bits_reg | sym_shifted;
                        valid_next = valid_reg + 3'd1;
                    end
                    fill_next = fill_reg + 3'd1;
                    flush_now = (fill_next == 3'd4);
                end
            end
            if (s_is_last && !stopped_next) begin
                flush_now = 1'b1;
            end

            // Flush the group: two to four valid characters give one to three bytes.
            if (flush_now) begin
                flush_count = (valid_next >= 3'd2) ? (valid_next - 3'd1) : 3'd0;
                remaining   = expected_reg - produced_reg;
                job.data[0] = bits_next[23:16];
                job.data[1] = bits_next[15:8];
                job.data[2] = bits_next[7:0];
                if (flush_count != 3'd0) begin
                    if (produced_reg >= expected_reg) begin
                        stopped_next = 1'b1;
                    end else if (remaining <= {13'd0, flush_count}) begin
                        job.count       = remaining[2:0];
                        job.last_status = stbc_pkg::STATUS_DONE;
                        produced_next   = expected_reg;
                        stopped_next    = 1'b1;
                    end else begin
                        job.count     = flush_count;
                        produced_next = produced_reg + {13'd0, flush_count};
                    end
                end
                bits_next  = '0;
                fill_next  = 3'd0;
                valid_next = 3'd0;
            end
        end

        // The final item of a stream clears the stream state.
        if (s_is_last) begin
            bits_next       = '0;
            fill_next       = 3'd0;
            valid_next      = 3'd0;
            lp_next         = '0;
            produced_next   = 16'd0;
            line_start_next = 1'b1;
            stopped_next    = 1'b0;
        end
    end

    // Configuration and stream state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= stbc_pkg::MODE_ENCODE;
            expected_reg   <= 16'd0;
            max_reg        <= 16'hFFFF;
            bits_reg       <= '0;
            fill_reg       <= 3'd0;
            valid_reg      <= 3'd0;
            lp_reg         <= '0;
            produced_reg   <= 16'd0;
            line_start_reg <= 1'b1;
            stopped_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                stbc_pkg::REG_MODE: begin
                    mode_reg       <= stbc_pkg::mode_t'(cfg_wr_data[0]);
                    bits_reg       <= '0;
                    fill_reg       <= 3'd0;
                    valid_reg      <= 3'd0;
                    lp_reg         <= '0;
                    produced_reg   <= 16'd0;
                    line_start_reg <= 1'b1;
                    stopped_reg    <= 1'b0;
                end
                stbc_pkg::REG_EXPECTED_LENGTH: expected_reg <= cfg_wr_data;
                stbc_pkg::REG_MAX_LENGTH:      max_reg      <= cfg_wr_data;
                default: begin
                end
            endcase
        end else if (accept) begin
            bits_reg       <= bits_next;
            fill_reg       <= fill_next;
            valid_reg      <= valid_next;
            lp_reg         <= lp_next;
            produced_reg   <= produced_next;
            line_start_reg <= line_start_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// File: src/stbc_queue.sv
// Short job queue between the front end and the back end of the codec.
// Depends on stbc_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module stbc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  stbc_pkg::job_t  push_data,
    output logic            full,
    input  wire             pop,
    output stbc_pkg::job_t  pop_data,
    output logic            empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] DepthV  = CntW'(DEPTH);

    stbc_pkg::job_t     entry_reg [DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [CntW-1:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == DepthV);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Storage is written at the tail only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/stbc_back.sv
// Back end of the codec: takes jobs from the queue and hands their results
// out one per cycle while m_ready is high. Depends on stbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stbc_back (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             q_empty,
    input  stbc_pkg::job_t  q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  wire             m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic [1:0]      m_status
);

    stbc_pkg::job_t  job_reg;
    logic [2:0]      idx_reg;
    logic            busy_reg;
    logic            at_last;

    assign at_last = (idx_reg == (job_reg.count - 3'd1));

    // Load the next job when idle or when the last result is taken.
    assign q_pop = !q_empty && (!busy_reg || (m_ready && at_last));

    assign m_valid    = busy_reg;
    assign m_out_byte = job_reg.data[idx_reg];
    assign m_run_last = at_last;
    assign m_status   = at_last ? job_reg.last_status : stbc_pkg::STATUS_OK;

    // Job payload needs no reset.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_data;
        end
    end

    // Result index and busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire
